>>> rtl/rti_pkg.sv
// Shared constants and types for the ray/triangle intersection block.
package rti_pkg;

    localparam int COORD_BITS  = 20;
    localparam int NORMAL_BITS = 16;
    localparam int VERT_BITS   = 60;
    localparam int NRM_BITS    = 48;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 60;
    // edge and offset components need one extra bit
    localparam int EW = COORD_BITS + 1;
    // cross product components
    localparam int CW = 2 * EW + 2;
    // dot products
    localparam int DW = CW + EW + 3;
    // wide work word for the back end
    localparam int WW = 128;
    localparam int QW = 33;
    // divider steps: quotient bits for t (saturation detect) and normals
    localparam int NQW = 17;
    localparam int QDEPTH = 4;
    localparam int QPTR = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_VERTEX_A = 3'd0,
        REG_VERTEX_B = 3'd1,
        REG_VERTEX_C = 3'd2,
        REG_NORMAL_A = 3'd3,
        REG_NORMAL_B = 3'd4,
        REG_NORMAL_C = 3'd5
    } t_reg_idx;

    // classified ray handed from front end to back end
    typedef struct packed {
        logic                  hit;
        logic [DW-1:0]         den;
        logic [DW-1:0]         un;
        logic [DW-1:0]         vn;
        logic [DW+16-1:0]      lhs;
    } t_job;

endpackage

>>> rtl/rti_if.sv
// Valid/ready channel interfaces for ray requests, results and configuration writes.
interface rti_ray_if;
    logic                      valid;
    logic                      ready;
    logic signed [rti_pkg::COORD_BITS-1:0] origin_x;
    logic signed [rti_pkg::COORD_BITS-1:0] origin_y;
    logic signed [rti_pkg::COORD_BITS-1:0] origin_z;
    logic signed [rti_pkg::COORD_BITS-1:0] dir_x;
    logic signed [rti_pkg::COORD_BITS-1:0] dir_y;
    logic signed [rti_pkg::COORD_BITS-1:0] dir_z;
    logic [31:0]               near_limit;
    logic [31:0]               far_limit;
    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    near_limit, far_limit, input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  near_limit, far_limit, output ready);
endinterface

interface rti_hit_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [31:0] hit_distance;
    logic signed [15:0] shade_normal_x;
    logic signed [15:0] shade_normal_y;
    logic signed [15:0] shade_normal_z;
    modport source (output valid, hit, hit_distance, shade_normal_x, shade_normal_y,
                    shade_normal_z, input ready);
    modport sink (input valid, hit, hit_distance, shade_normal_x, shade_normal_y,
                  shade_normal_z, output ready);
endinterface

interface rti_cfg_if;
    logic        valid;
    logic        ready;
    logic [rti_pkg::CFG_IDX_BITS-1:0]  index;
    logic [rti_pkg::CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/ray_triangle_intersect.sv
// Top level of the ray/triangle intersection block.
// One ray request is accepted per clock while the front end is not stalled, and
// each gives one result. A request passes through the geometry front end
// (differences, cross products, dot products, sign fix, window partial
// products, window compare), the four-entry queue, and the back end
// (numerator products, numerator sum, 33 restoring divider stages for t and
// the three blended normal components, output register). A stalled result
// holds the back end; the queue lets the front end keep accepting until it
// fills. Triangle vertices and normals are written through the configuration channel
// only while the block is idle; the user must keep to this, the block does not enforce it.
module ray_triangle_intersect (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rti_cfg_if.sink   cfg,
    rti_ray_if.sink   ray,
    rti_hit_if.source hit
);
    logic [rti_pkg::VERT_BITS-1:0] r_va, r_vb, r_vc;
    logic [rti_pkg::NRM_BITS-1:0]  r_na, r_nb, r_nc;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= '0; r_vb <= '0; r_vc <= '0;
            r_na <= '0; r_nb <= '0; r_nc <= '0;
        end else if (cfg.valid) begin
            case (cfg.index)
                rti_pkg::REG_VERTEX_A: r_va <= cfg.data;
                rti_pkg::REG_VERTEX_B: r_vb <= cfg.data;
                rti_pkg::REG_VERTEX_C: r_vc <= cfg.data;
                rti_pkg::REG_NORMAL_A: r_na <= cfg.data[rti_pkg::NRM_BITS-1:0];
                rti_pkg::REG_NORMAL_B: r_nb <= cfg.data[rti_pkg::NRM_BITS-1:0];
                rti_pkg::REG_NORMAL_C: r_nc <= cfg.data[rti_pkg::NRM_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic f_valid, f_ready, q_valid, q_ready;
    rti_pkg::t_job f_job, q_job;

    rti_front u_front (.i_clk, .i_rst_n, .i_va(r_va), .i_vb(r_vb), .i_vc(r_vc), .ray(ray),
                       .i_ready(f_ready), .o_valid(f_valid), .o_job(f_job));
    rti_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_job(f_job),
                       .o_valid(q_valid), .i_ready(q_ready), .o_job(q_job));
    rti_back  u_back  (.i_clk, .i_rst_n, .i_na(r_na), .i_nb(r_nb), .i_nc(r_nc),
                       .i_valid(q_valid), .o_ready(q_ready), .i_job(q_job), .hit(hit));
endmodule

>>> rtl/rti_front.sv
// Front end: edge vectors, cross and dot products, sign fix and window classification.
module rti_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [rti_pkg::VERT_BITS-1:0] i_va,
    input  logic [rti_pkg::VERT_BITS-1:0] i_vb,
    input  logic [rti_pkg::VERT_BITS-1:0] i_vc,
    rti_ray_if.sink                  ray,
    input  logic                     i_ready,
    output logic                     o_valid,
    output rti_pkg::t_job            o_job
);
    localparam int EW = rti_pkg::EW;
    localparam int CW = rti_pkg::CW;
    localparam int DW = rti_pkg::DW;
    localparam int CB = rti_pkg::COORD_BITS;
    // window partial products and full window products
    localparam int PW = DW + 16;
    localparam int LW = DW + 32;

    // pipeline valids and enable
    logic [5:0] r_v;
    logic       en;
    assign en = i_ready || !r_v[5];
    assign ray.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[4:0], ray.valid};
    end

    // stage 1: differences
    logic signed [EW-1:0] r_e1 [3], r_e2 [3], r_s [3], r_d [3];
    logic [31:0] r_near1, r_far1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_e1[k] <= EW'($signed(i_vb[k*CB +: CB])) - EW'($signed(i_va[k*CB +: CB]));
                r_e2[k] <= EW'($signed(i_vc[k*CB +: CB])) - EW'($signed(i_va[k*CB +: CB]));
            end
            r_s[0] <= EW'(ray.origin_x) - EW'($signed(i_va[0 +: CB]));
            r_s[1] <= EW'(ray.origin_y) - EW'($signed(i_va[CB +: CB]));
            r_s[2] <= EW'(ray.origin_z) - EW'($signed(i_va[2*CB +: CB]));
            r_d[0] <= EW'(ray.dir_x);
            r_d[1] <= EW'(ray.dir_y);
            r_d[2] <= EW'(ray.dir_z);
            r_near1 <= ray.near_limit;
            r_far1  <= ray.far_limit;
        end
    end

    // stage 2: cross products s1 = d x e2, s2 = s x e1
    logic signed [CW-1:0] r_s1 [3], r_s2 [3];
    logic signed [EW-1:0] r_e1b [3], r_e2b [3], r_sb [3], r_db [3];
    logic [31:0] r_near2, r_far2;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_s1[k] <= CW'(r_d[(k+1)%3] * r_e2[(k+2)%3]) - CW'(r_d[(k+2)%3] * r_e2[(k+1)%3]);
                r_s2[k] <= CW'(r_s[(k+1)%3] * r_e1[(k+2)%3]) - CW'(r_s[(k+2)%3] * r_e1[(k+1)%3]);
            end
            r_e1b <= r_e1; r_e2b <= r_e2; r_sb <= r_s; r_db <= r_d;
            r_near2 <= r_near1; r_far2 <= r_far1;
        end
    end

    // stage 3: dot products
    logic signed [DW-1:0] r_den, r_tn, r_un, r_vn;
    logic [31:0] r_near3, r_far3;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= DW'(r_s1[0]*r_e1b[0]) + DW'(r_s1[1]*r_e1b[1]) + DW'(r_s1[2]*r_e1b[2]);
            r_tn  <= DW'(r_s2[0]*r_e2b[0]) + DW'(r_s2[1]*r_e2b[1]) + DW'(r_s2[2]*r_e2b[2]);
            r_un  <= DW'(r_s1[0]*r_sb[0])  + DW'(r_s1[1]*r_sb[1])  + DW'(r_s1[2]*r_sb[2]);
            r_vn  <= DW'(r_s2[0]*r_db[0])  + DW'(r_s2[1]*r_db[1])  + DW'(r_s2[2]*r_db[2]);
            r_near3 <= r_near2; r_far3 <= r_far2;
        end
    end

    // stage 4: sign normalise so the denominator is positive
    logic signed [DW-1:0] r_den4, r_tn4, r_un4, r_vn4;
    logic        r_zero4;
    logic [31:0] r_near4, r_far4;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_zero4 <= (r_den == '0);
            r_den4  <= r_den[DW-1] ? -r_den : r_den;
            r_tn4   <= r_den[DW-1] ? -r_tn  : r_tn;
            r_un4   <= r_den[DW-1] ? -r_un  : r_un;
            r_vn4   <= r_den[DW-1] ? -r_vn  : r_vn;
            r_near4 <= r_near3; r_far4 <= r_far3;
        end
    end

    // stage 5: den times window limits in 16-bit halves, sign and weight checks
    logic [PW-1:0]        r_nlo, r_nhi, r_flo, r_fhi;
    logic                 r_early5;
    logic signed [DW-1:0] r_den5, r_un5, r_vn5;
    logic [DW+15:0]       r_lhs5;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nlo <= PW'(r_den4) * PW'(r_near4[15:0]);
            r_nhi <= PW'(r_den4) * PW'(r_near4[31:16]);
            r_flo <= PW'(r_den4) * PW'(r_far4[15:0]);
            r_fhi <= PW'(r_den4) * PW'(r_far4[31:16]);
            r_early5 <= r_zero4 || r_tn4[DW-1] || r_un4[DW-1] || r_vn4[DW-1]
                     || ((DW+1)'(r_un4) + (DW+1)'(r_vn4) > (DW+1)'(r_den4));
            r_lhs5 <= {r_tn4, 16'd0};
            r_den5 <= r_den4;
            r_un5  <= r_un4;
            r_vn5  <= r_vn4;
        end
    end

    // stage 6: exact window compare, near <= t <= far
    logic [LW-1:0] lo_w, hi_w;
    logic miss;
    always_comb begin
        lo_w = LW'(r_nlo) + (LW'(r_nhi) << 16);
        hi_w = LW'(r_flo) + (LW'(r_fhi) << 16);
        miss = r_early5 || (LW'(r_lhs5) < lo_w) || (LW'(r_lhs5) > hi_w);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_job.hit <= !miss;
            o_job.den <= r_den5;
            o_job.un  <= r_un5;
            o_job.vn  <= r_vn5;
            o_job.lhs <= r_lhs5;
        end
    end
    assign o_valid = r_v[5];

endmodule

>>> rtl/rti_queue.sv
// Short request queue between the front and back ends.
module rti_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  rti_pkg::t_job i_job,
    output logic          o_valid,
    input  logic          i_ready,
    output rti_pkg::t_job o_job
);
    localparam int P = rti_pkg::QPTR;
    rti_pkg::t_job r_mem [rti_pkg::QDEPTH];
    logic [P:0] r_wp, r_rp;
    logic push, pop;

    assign o_ready = (r_wp - r_rp) != (P+1)'(rti_pkg::QDEPTH);
    assign o_valid = r_wp != r_rp;
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    assign o_job = r_mem[r_rp[P-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp[P-1:0]] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wp - r_rp) <= (P+1)'(rti_pkg::QDEPTH)) else $error("queue overflow");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_wp != r_rp)) else $error("pop from empty queue");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> !push) else $error("push while full");
endmodule

>>> rtl/rti_back.sv
// Back end: pipelined restoring dividers for t and the blended normal, with saturation.
module rti_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [rti_pkg::NRM_BITS-1:0] i_na,
    input  logic [rti_pkg::NRM_BITS-1:0] i_nb,
    input  logic [rti_pkg::NRM_BITS-1:0] i_nc,
    input  logic          i_valid,
    output logic          o_ready,
    input  rti_pkg::t_job i_job,
    rti_hit_if.source     hit
);
    localparam int DW = rti_pkg::DW;
    localparam int NB = rti_pkg::NORMAL_BITS;
    localparam int QW = rti_pkg::QW;
    localparam int NQ = rti_pkg::NQW;
    localparam int NW = DW + NB + 2;
    localparam int ST = QW;

    // stage 0: blended numerators (one multiply per term, summed next)
    logic [ST+2:0] r_v;
    logic en;
    assign en = hit.ready || !hit.valid;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else if (en) r_v <= {r_v[ST+1:0], i_valid};
    end

    logic signed [NW-1:0] r_pa [3], r_pb [3], r_pc [3];
    rti_pkg::t_job r_j0;
    logic signed [DW:0] wa;
    assign wa = (DW+1)'(i_job.den) - (DW+1)'(i_job.un) - (DW+1)'(i_job.vn);
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[k] <= NW'(wa) * NW'($signed(i_na[k*NB +: NB]));
                r_pb[k] <= NW'($signed({1'b0, i_job.un})) * NW'($signed(i_nb[k*NB +: NB]));
                r_pc[k] <= NW'($signed({1'b0, i_job.vn})) * NW'($signed(i_nc[k*NB +: NB]));
            end
            r_j0 <= i_job;
        end
    end

    // divider pipeline: one quotient bit per stage, all four dividends in parallel
    logic [DW+15:0]  r_tr [ST+1];
    logic [QW-1:0]   r_tq [ST+1];
    logic [NW-1:0]   r_nr [ST+1][3];
    logic [NQ-1:0]   r_nq [ST+1][3];
    logic            r_ng [ST+1][3];
    logic [DW-1:0]   r_dd [ST+1];
    logic            r_h  [ST+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                logic signed [NW-1:0] num;
                num = r_pa[k] + r_pb[k] + r_pc[k];
                r_ng[0][k] <= num[NW-1];
                r_nr[0][k] <= num[NW-1] ? NW'(-num) : NW'(num);
                r_nq[0][k] <= '0;
            end
            r_tr[0] <= r_j0.lhs;
            r_tq[0] <= '0;
            r_dd[0] <= r_j0.den;
            r_h[0]  <= r_j0.hit;
        end
    end

    for (genvar g = 0; g < ST; g++) begin : g_div
        localparam int TSH = QW - 1 - g;
        // normal quotients only need the first NQ steps
        localparam int NSH = (g < NQ) ? (NQ - 1 - g) : 0;
        always_ff @(posedge i_clk) begin
            if (en) begin
                logic [DW+15+QW:0] dsh;
                logic [NW+NQ:0]   nsh;
                dsh = (DW+16+QW)'(r_dd[g]) << TSH;
                if ((DW+16+QW)'(r_tr[g]) >= dsh) begin
                    r_tr[g+1] <= (DW+16)'((DW+16+QW)'(r_tr[g]) - dsh);
                    r_tq[g+1] <= r_tq[g] | (QW'(1) << TSH);
                end else begin
                    r_tr[g+1] <= r_tr[g];
                    r_tq[g+1] <= r_tq[g];
                end
                for (int k = 0; k < 3; k++) begin
                    nsh = (NW+NQ+1)'(r_dd[g]) << NSH;
                    if (g < NQ && (NW+NQ+1)'(r_nr[g][k]) >= nsh) begin
                        r_nr[g+1][k] <= NW'((NW+NQ+1)'(r_nr[g][k]) - nsh);
                        r_nq[g+1][k] <= r_nq[g][k] | (NQ'(1) << NSH);
                    end else begin
                        r_nr[g+1][k] <= r_nr[g][k];
                        r_nq[g+1][k] <= r_nq[g][k];
                    end
                    r_ng[g+1][k] <= r_ng[g][k];
                end
                r_dd[g+1] <= r_dd[g];
                r_h[g+1]  <= r_h[g];
            end
        end
    end

    // output register: saturate, zero on miss
    logic [15:0] nout [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [NQ-1:0] lim;
            logic [NQ-1:0] m;
            lim = r_ng[ST][k] ? NQ'(32768) : NQ'(32767);
            m = (r_nq[ST][k] > lim) ? lim : r_nq[ST][k];
            nout[k] = r_ng[ST][k] ? 16'(-m) : 16'(m);
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            hit.hit            <= r_h[ST];
            hit.hit_distance   <= !r_h[ST] ? 32'd0 : (r_tq[ST][QW-1] ? 32'hFFFF_FFFF
                                                      : r_tq[ST][31:0]);
            hit.shade_normal_x <= r_h[ST] ? nout[0] : 16'd0;
            hit.shade_normal_y <= r_h[ST] ? nout[1] : 16'd0;
            hit.shade_normal_z <= r_h[ST] ? nout[2] : 16'd0;
        end
    end
    assign hit.valid = r_v[ST+2];

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit.valid && !hit.hit) |-> (hit.hit_distance == 32'd0)) else $error("miss with t");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (hit.valid && !hit.ready) |=> hit.valid) else $error("result dropped");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !hit.valid |-> o_ready) else $error("stall while empty");
endmodule
